// ----- rtl/pvm_pkg.sv -----
package pvm_pkg;

	localparam int DEF_MAX_VOICES   = 8;
	localparam int DEF_CLIP_DEPTH   = 4096;
	localparam int DEF_MAX_CHANNELS = 8;

	localparam logic [3:0] CHANNELS_RESET = 4'd2;

	localparam logic signed [16:0] SAMPLE_MAX = 17'sd32767;
	localparam logic signed [16:0] SAMPLE_MIN = -17'sd32768;

	typedef enum logic [1:0] {
		FUNC_APPEND = 2'd0,
		FUNC_START  = 2'd1,
		FUNC_RENDER = 2'd2,
		FUNC_STOP   = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_VOICE,
		ST_READ,
		ST_DRAIN,
		ST_EMIT
	} state_t;

endpackage

// ----- rtl/pvm_clip_mem.sv -----
module pvm_clip_mem #(
	parameter int DEPTH = 36864,
	parameter int AW    = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [15:0]       wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [15:0]       rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/pcm_voice_mixer.sv -----
// sequence: append and stop are handled in idle; a start that makes a voice passes through find,
// which picks the next staging slot; a render visits each voice, drops one that has no whole frame
// left, reads one clip sample per channel for each playing voice, then emits one beat per channel
// throughput: one item at a time, since s_tready is high only in idle; one clip memory read port
// reset: no voices, staging slot MAX_VOICES, stream_channels 2; clip memory not cleared
module pcm_voice_mixer #(
	parameter int MAX_VOICES   = pvm_pkg::DEF_MAX_VOICES,
	parameter int CLIP_DEPTH   = pvm_pkg::DEF_CLIP_DEPTH,
	parameter int MAX_CHANNELS = pvm_pkg::DEF_MAX_CHANNELS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // sample[15:0], clip_channels[19:16], zero pad
	input  logic [1:0]  s_tuser,   // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // mixed_sample[15:0], channel_index[18:16], zero pad
	output logic        m_tlast
);

	localparam int SLOTS = MAX_VOICES + 1;
	localparam int SW    = $clog2(SLOTS);
	localparam int VW    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
	localparam int LW    = $clog2(CLIP_DEPTH + 1);
	localparam int PW    = LW + 4;
	localparam int DEPTH = SLOTS * CLIP_DEPTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	pvm_pkg::state_t state_q, state_d;

	logic [3:0]    chans_q;
	logic [LW-1:0] vlen_q [SLOTS];
	logic [LW-1:0] pos_q  [MAX_VOICES];
	logic [SW-1:0] age_q  [MAX_VOICES];
	logic [SW:0]   active_q;
	logic [SW-1:0] stg_slot_q;
	logic [LW-1:0] stg_cnt_q;
	logic [SW:0]   vi_q;
	logic [CW-1:0] c_q;
	logic [CW-1:0] emit_q;
	logic [AW-1:0] base_q;
	logic [PW-1:0] p1_q;
	logic signed [15:0] acc_q [MAX_CHANNELS];

	logic          rd_v_s1;
	logic [CW-1:0] rd_c_s1;

	logic              acc_beat;
	pvm_pkg::func_t    func;
	logic [15:0]       in_sample;
	logic [3:0]        in_ch;
	logic              chans_ok;

	logic [VW-1:0] vi_idx;
	logic [SW-1:0] cur_slot;
	logic [LW-1:0] cur_len;
	logic [LW-1:0] cur_pos;
	logic [PW-1:0] p1;
	logic          can_play;
	logic          keep_voice;
	logic          cur_valid;
	logic [SW-1:0] free_slot;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem_rdata;

	assign acc_beat  = s_tvalid && s_tready;
	assign func      = pvm_pkg::func_t'(s_tuser);
	assign in_sample = s_tdata[15:0];
	assign in_ch     = s_tdata[19:16];
	assign chans_ok  = (chans_q != 4'd0) && (32'(chans_q) <= MAX_CHANNELS);

	// current voice under render
	assign cur_valid = vi_q < active_q;
	assign vi_idx    = (vi_q < (SW+1)'(MAX_VOICES)) ? vi_q[VW-1:0] : '0;
	assign cur_slot  = age_q[vi_idx];
	assign cur_len   = vlen_q[cur_slot];
	assign cur_pos   = pos_q[vi_idx];
	assign p1        = PW'(PW'(cur_pos) + PW'(1)) * PW'(chans_q);
	assign can_play  = p1 <= PW'(cur_len);
	// after this frame, another whole frame remains
	assign keep_voice = (p1_q + PW'(chans_q)) <= PW'(vlen_q[cur_slot]);

	// first slot not held by an active voice
	always_comb begin
		logic found;
		logic used;
		found     = 1'b0;
		free_slot = '0;
		for (int s = 0; s < SLOTS; s++) begin
			used = 1'b0;
			for (int k = 0; k < MAX_VOICES; k++) begin
				if ((SW+1)'(k) < active_q && age_q[k] == SW'(s)) begin
					used = 1'b1;
				end
			end
			if (!used && !found) begin
				found     = 1'b1;
				free_slot = SW'(s);
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pvm_pkg::ST_IDLE: begin
				if (acc_beat) begin
					if (func == pvm_pkg::FUNC_START) begin
						if (stg_cnt_q != '0 && in_ch == chans_q && chans_ok) begin
							state_d = pvm_pkg::ST_FIND;
						end
					end else if (func == pvm_pkg::FUNC_RENDER && chans_ok) begin
						state_d = pvm_pkg::ST_VOICE;
					end
				end
			end
			pvm_pkg::ST_FIND:  state_d = pvm_pkg::ST_IDLE;
			pvm_pkg::ST_VOICE: begin
				if (!cur_valid) begin
					state_d = pvm_pkg::ST_EMIT;
				end else if (can_play) begin
					state_d = pvm_pkg::ST_READ;
				end
			end
			pvm_pkg::ST_READ: begin
				if (4'(c_q) + 4'd1 == chans_q) begin
					state_d = pvm_pkg::ST_DRAIN;
				end
			end
			pvm_pkg::ST_DRAIN: state_d = pvm_pkg::ST_VOICE;
			pvm_pkg::ST_EMIT: begin
				if (m_tready && 4'(emit_q) + 4'd1 == chans_q) begin
					state_d = pvm_pkg::ST_IDLE;
				end
			end
			default: state_d = pvm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = state_q == pvm_pkg::ST_IDLE;
		m_tvalid  = state_q == pvm_pkg::ST_EMIT;
		m_tdata   = {5'd0, 3'(emit_q), acc_q[emit_q]};
		m_tlast   = 4'(emit_q) + 4'd1 == chans_q;
		mem_we    = acc_beat && func == pvm_pkg::FUNC_APPEND && 32'(stg_cnt_q) < CLIP_DEPTH;
		mem_waddr = AW'(stg_slot_q) * AW'(CLIP_DEPTH) + AW'(stg_cnt_q);
		mem_re    = state_q == pvm_pkg::ST_READ;
		mem_raddr = base_q + AW'(c_q);
	end

	pvm_clip_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (in_sample),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= mem_re;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [16:0] sum;
		rd_c_s1 <= c_q;
		if (state_q == pvm_pkg::ST_IDLE) begin
			for (int c = 0; c < MAX_CHANNELS; c++) begin
				acc_q[c] <= '0;
			end
		end else if (rd_v_s1) begin
			sum = 17'(acc_q[rd_c_s1]) + 17'(signed'(mem_rdata));
			if (sum > pvm_pkg::SAMPLE_MAX) begin
				sum = pvm_pkg::SAMPLE_MAX;
			end else if (sum < pvm_pkg::SAMPLE_MIN) begin
				sum = pvm_pkg::SAMPLE_MIN;
			end
			acc_q[rd_c_s1] <= sum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pvm_pkg::ST_IDLE;
			chans_q    <= pvm_pkg::CHANNELS_RESET;
			active_q   <= '0;
			stg_slot_q <= SW'(MAX_VOICES);
			stg_cnt_q  <= '0;
			vi_q       <= '0;
			c_q        <= '0;
			emit_q     <= '0;
			base_q     <= '0;
			p1_q       <= '0;
			for (int s = 0; s < SLOTS; s++) begin
				vlen_q[s] <= '0;
			end
			for (int k = 0; k < MAX_VOICES; k++) begin
				pos_q[k] <= '0;
				age_q[k] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				chans_q <= cfg_data;
			end
			unique case (state_q)
				pvm_pkg::ST_IDLE: begin
					vi_q   <= '0;
					emit_q <= '0;
					if (acc_beat) begin
						unique case (func)
							pvm_pkg::FUNC_APPEND: begin
								if (32'(stg_cnt_q) < CLIP_DEPTH) begin
									stg_cnt_q <= stg_cnt_q + LW'(1);
								end
							end
							pvm_pkg::FUNC_START: begin
								stg_cnt_q <= '0;
								if (stg_cnt_q != '0 && in_ch == chans_q && chans_ok) begin
									vlen_q[stg_slot_q] <= stg_cnt_q;
									if (32'(active_q) >= MAX_VOICES) begin
										// evict the oldest voice
										for (int k = 0; k + 1 < MAX_VOICES; k++) begin
											age_q[k] <= age_q[k+1];
											pos_q[k] <= pos_q[k+1];
										end
										age_q[MAX_VOICES-1] <= stg_slot_q;
										pos_q[MAX_VOICES-1] <= '0;
									end else begin
										age_q[active_q[VW-1:0]] <= stg_slot_q;
										pos_q[active_q[VW-1:0]] <= '0;
										active_q <= active_q + (SW+1)'(1);
									end
								end
							end
							pvm_pkg::FUNC_RENDER: ;
							pvm_pkg::FUNC_STOP:   active_q <= '0;
							default: ;
						endcase
					end
				end
				pvm_pkg::ST_FIND: stg_slot_q <= free_slot;
				pvm_pkg::ST_VOICE: begin
					c_q <= '0;
					if (cur_valid) begin
						if (can_play) begin
							p1_q   <= p1;
							base_q <= AW'(cur_slot) * AW'(CLIP_DEPTH)
								+ AW'(p1 - PW'(chans_q));
						end else begin
							for (int k = 0; k + 1 < MAX_VOICES; k++) begin
								if ((SW+1)'(k) >= vi_q && (SW+1)'(k + 1) < active_q) begin
									age_q[k] <= age_q[k+1];
									pos_q[k] <= pos_q[k+1];
								end
							end
							active_q <= active_q - (SW+1)'(1);
						end
					end
				end
				pvm_pkg::ST_READ: c_q <= c_q + CW'(1);
				pvm_pkg::ST_DRAIN: begin
					if (keep_voice) begin
						pos_q[vi_idx] <= cur_pos + LW'(1);
						vi_q <= vi_q + (SW+1)'(1);
					end else begin
						for (int k = 0; k + 1 < MAX_VOICES; k++) begin
							if ((SW+1)'(k) >= vi_q && (SW+1)'(k + 1) < active_q) begin
								age_q[k] <= age_q[k+1];
								pos_q[k] <= pos_q[k+1];
							end
						end
						active_q <= active_q - (SW+1)'(1);
					end
				end
				pvm_pkg::ST_EMIT: begin
					if (m_tready) begin
						emit_q <= emit_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule
